// ----- design/slcfr_pkg.sv -----
// Package for the sync/length/checksum frame receiver.
// Shared constants and the structs passed between front, queue and back.
// No dependencies.
package slcfr_pkg;

	localparam int BUFFER_BYTES = 64;          // frame buffer size incl. length byte
	localparam int IDX_W        = 6;           // payload index / length width
	localparam int LEN_W        = 7;           // frame length / byte count width
	localparam int ADDR_W       = IDX_W + 1;   // bank bit + payload index

	localparam logic [7:0] SYNC_RESET = 8'h5a;

	// frame descriptor handed from front to back
	typedef struct packed {
		logic             bank;
		logic [7:0]       command;
		logic [IDX_W-1:0] plen;
	} desc_t;

	// payload write into the buffer owned by the back end
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

endpackage

// ----- design/sync_length_checksum_frame_receiver.sv -----
// Top level of the sync/length/checksum frame receiver.
// Depends on slcfr_pkg, slcfr_front, slcfr_desc_fifo and slcfr_back.
//
// Received bytes are pushed one beat at a time; the front end takes a byte every
// cycle unless full is high. A frame is two consecutive sync_value bytes, a
// length byte (counting itself, the command and the payload, clamped to 64,
// abandoned if below 2), the command, the payload and an 8-bit wrapping sum of
// length, command and payload. A good frame is replayed as one result per
// payload byte, or as a single has_data=0 result for an empty payload; a bad
// sum drops it silently. Payload is kept in a two-bank buffer, so the next
// frame can be received while the previous one is still being replayed; full
// rises only when both banks hold frames awaiting replay, and falls as soon as
// the oldest one has been read out. Replay runs at one result per cycle
// while pop keeps up, set by the single read port of the buffer; each result
// is registered out of the buffer read before it shows. sync_value is written
// over its own valid/ready channel, which is always ready; it should only be
// changed while the receiver is idle. There is no clearing pass after reset.

module sync_length_checksum_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// receive side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	// result side
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  command,
	output logic [7:0]  data_byte,
	output logic [5:0]  byte_index,
	output logic [5:0]  payload_length,
	output logic        has_data,
	output logic        last,
	// sync_value register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	slcfr_pkg::buf_wr_t buf_wr;
	slcfr_pkg::desc_t   push_desc;
	slcfr_pkg::desc_t   head_desc;
	logic               desc_push;
	logic               desc_pop;
	logic               desc_valid;
	logic               desc_full;
	logic               beat;

	// both banks claimed: hold the sender off until replay frees one
	assign full      = desc_full;
	assign beat      = push && !desc_full;
	assign cfg_ready = 1'b1;

	slcfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.buf_wr    (buf_wr),
		.desc_push (desc_push),
		.desc      (push_desc)
	);

	slcfr_desc_fifo u_desc_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (desc_push),
		.wr_desc   (push_desc),
		.rd        (desc_pop),
		.rd_desc   (head_desc),
		.not_empty (desc_valid),
		.is_full   (desc_full)
	);

	slcfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.buf_wr         (buf_wr),
		.desc_valid     (desc_valid),
		.desc           (head_desc),
		.desc_pop       (desc_pop),
		.pop            (pop),
		.empty          (empty),
		.command        (command),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.payload_length (payload_length),
		.has_data       (has_data),
		.last           (last)
	);

endmodule

// ----- design/slcfr_front.sv -----
// Front end: sync hunt, length, payload capture and checksum check.
// Depends on slcfr_pkg; pushes descriptors, writes payload via buf_wr_t.
module slcfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat,        // accepted rx beat
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data,
	output slcfr_pkg::buf_wr_t   buf_wr,
	output logic                 desc_push,
	output slcfr_pkg::desc_t     desc
);

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	logic [1:0]                      phase_q;
	logic                            sync_seen_q;
	logic [slcfr_pkg::LEN_W-1:0]     byte_count_q;
	logic [slcfr_pkg::LEN_W-1:0]     frame_length_q;
	logic [7:0]                      sum_q;
	logic [7:0]                      sync_value_q;
	logic [7:0]                      command_q;
	logic                            bank_q;

	logic [slcfr_pkg::LEN_W-1:0]     len_clamp;
	logic [slcfr_pkg::LEN_W-1:0]     count_inc;
	logic                            store;

	assign len_clamp = (rx_byte > 8'(slcfr_pkg::BUFFER_BYTES)) ?
		slcfr_pkg::LEN_W'(slcfr_pkg::BUFFER_BYTES) : rx_byte[slcfr_pkg::LEN_W-1:0];
	assign count_inc = byte_count_q + 1'b1;
	assign store     = beat && (phase_q == PH_DATA) && (byte_count_q < frame_length_q);

	// command byte sits at position one, payload from position two onwards
	assign buf_wr.en   = store && (byte_count_q != slcfr_pkg::LEN_W'(1));
	assign buf_wr.addr = {bank_q, slcfr_pkg::IDX_W'(byte_count_q - slcfr_pkg::LEN_W'(2))};
	assign buf_wr.data = rx_byte;

	assign desc_push    = beat && (phase_q == PH_SUM) && (rx_byte == sum_q);
	assign desc.bank    = bank_q;
	assign desc.command = command_q;
	assign desc.plen    = slcfr_pkg::IDX_W'(frame_length_q - slcfr_pkg::LEN_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= slcfr_pkg::SYNC_RESET;
		end else if (cfg_we) begin
			sync_value_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (store && (byte_count_q == slcfr_pkg::LEN_W'(1))) begin
			command_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SYNC;
			sync_seen_q    <= 1'b0;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			sum_q          <= '0;
			bank_q         <= 1'b0;
		end else if (beat) begin
			case (phase_q)
				PH_SYNC: begin
					if (rx_byte == sync_value_q) begin
						if (sync_seen_q) begin
							sync_seen_q  <= 1'b0;
							byte_count_q <= '0;
							sum_q        <= '0;
							phase_q      <= PH_LEN;
						end else begin
							sync_seen_q <= 1'b1;
						end
					end else begin
						sync_seen_q <= 1'b0;
					end
				end
				PH_LEN: begin
					if (len_clamp < slcfr_pkg::LEN_W'(2)) begin
						byte_count_q <= '0;
						phase_q      <= PH_SYNC;
					end else begin
						frame_length_q <= len_clamp;
						sum_q          <= {1'b0, len_clamp};
						byte_count_q   <= slcfr_pkg::LEN_W'(1);
						phase_q        <= PH_DATA;
					end
				end
				PH_DATA: begin
					if (store) begin
						byte_count_q <= count_inc;
						sum_q        <= sum_q + rx_byte;
						if (count_inc >= frame_length_q) begin
							phase_q <= PH_SUM;
						end
					end else begin
						phase_q <= PH_SUM;
					end
				end
				default: begin
					if (desc_push) begin
						bank_q <= ~bank_q;    // next frame goes to the other bank
					end
					byte_count_q <= '0;
					phase_q      <= PH_SYNC;
				end
			endcase
		end
	end

endmodule

// ----- design/slcfr_desc_fifo.sv -----
// Two-entry descriptor queue between front and back ends.
// Depends on slcfr_pkg for desc_t.
module slcfr_desc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  slcfr_pkg::desc_t  wr_desc,
	input  logic              rd,
	output slcfr_pkg::desc_t  rd_desc,
	output logic              not_empty,
	output logic              is_full
);

	slcfr_pkg::desc_t slot_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       count_q;

	assign rd_desc   = slot_q[rp_q];
	assign not_empty = (count_q != 2'd0);
	assign is_full   = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/slcfr_back.sv -----
// Back end: two-bank payload buffer and frame replay, one result per cycle while pop keeps up.
// Depends on slcfr_pkg; reads descriptors from slcfr_desc_fifo.
module slcfr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slcfr_pkg::buf_wr_t           buf_wr,
	input  logic                         desc_valid,
	input  slcfr_pkg::desc_t             desc,
	output logic                         desc_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [7:0]                   command,
	output logic [7:0]                   data_byte,
	output logic [slcfr_pkg::IDX_W-1:0]  byte_index,
	output logic [slcfr_pkg::IDX_W-1:0]  payload_length,
	output logic                         has_data,
	output logic                         last
);

	logic [7:0]                  mem [2**slcfr_pkg::ADDR_W];
	logic [7:0]                  rdata_q;
	logic [slcfr_pkg::IDX_W-1:0] idx_q;
	logic                        out_valid_q;
	logic [7:0]                  cmd_q;
	logic [slcfr_pkg::IDX_W-1:0] bidx_q;
	logic [slcfr_pkg::IDX_W-1:0] plen_q;
	logic                        has_q;
	logic                        last_q;

	logic issue;
	logic empty_frame;
	logic is_last;

	assign issue       = desc_valid && (!out_valid_q || pop);
	assign empty_frame = (desc.plen == '0);
	assign is_last     = empty_frame || ((idx_q + 1'b1) == desc.plen);
	assign desc_pop    = issue && is_last;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr] <= buf_wr.data;
		end
		if (issue) begin
			rdata_q <= mem[{desc.bank, idx_q}];
			cmd_q   <= desc.command;
			bidx_q  <= idx_q;
			plen_q  <= desc.plen;
			has_q   <= !empty_frame;
			last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign command        = cmd_q;
	assign data_byte      = has_q ? rdata_q : 8'd0;
	assign byte_index     = bidx_q;
	assign payload_length = plen_q;
	assign has_data       = has_q;
	assign last           = last_q;

endmodule

// ----- test/sync_length_checksum_frame_receiver_test.sv -----
// Testbench for the sync/length/checksum frame receiver.
// Depends on slcfr_pkg and sync_length_checksum_frame_receiver; self-checking,
// with a frame predictor in a scoreboard class and random idling on both sides.
`timescale 1ns / 100ps

module sync_length_checksum_frame_receiver_test;

	localparam int CLK_HALF        = 2;       // 4 ns period
	localparam int RESET_CYCLES    = 10;
	localparam int GROUP_BYTES     = 6;       // minimum rx beats per random group
	localparam int PRESSURE_FRAMES = 4;       // enough to fill both banks and stall push
	localparam int HOLD_CYCLES     = 500;     // long receiver hold-off
	localparam int TAIL_CYCLES     = 16;      // front end settle time after the last owed result
	localparam int LIMIT_CYCLES    = 200000;

	// receive state, tracked the same way the front end walks a frame
	typedef enum logic [1:0] {
		RX_HUNT,
		RX_LENGTH,
		RX_BODY,
		RX_CHECK
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic [5:0] payload_length;
		logic       has_data;
		logic       last;
	} frame_reply_t;

	// Predicts the replayed results of every frame and checks each popped beat
	// against the oldest one still owed.
	class frame_scoreboard;
		bit [7:0]     sync_value;
		rx_phase_t    phase;
		bit           sync_seen;
		bit [6:0]     byte_count;
		bit [6:0]     frame_length;
		bit [7:0]     running_sum;
		bit [7:0]     frame_store [slcfr_pkg::BUFFER_BYTES];
		frame_reply_t expected [$];
		int           errors;

		function new();
			sync_value   = slcfr_pkg::SYNC_RESET;
			phase        = RX_HUNT;
			sync_seen    = 1'b0;
			byte_count   = '0;
			frame_length = '0;
			running_sum  = '0;
			errors       = 0;
		endfunction

		function void set_sync(bit [7:0] value);
			sync_value = value;
		endfunction

		function bit at_rest();
			return phase == RX_HUNT && !sync_seen;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// one accepted rx beat
		function void note_byte(bit [7:0] b);
			int unsigned  len;
			int unsigned  plen;
			frame_reply_t r;
			case (phase)
				RX_HUNT: begin
					if (b == sync_value) begin
						if (sync_seen) begin
							sync_seen   = 1'b0;
							byte_count  = '0;
							running_sum = '0;
							phase       = RX_LENGTH;
						end else begin
							sync_seen = 1'b1;
						end
					end else begin
						sync_seen = 1'b0;
					end
				end
				RX_LENGTH: begin
					len = (b > slcfr_pkg::BUFFER_BYTES) ? slcfr_pkg::BUFFER_BYTES : b;
					if (len < 2) begin
						byte_count = '0;
						phase      = RX_HUNT;
					end else begin
						frame_length  = len[6:0];
						frame_store[0] = len[7:0];
						running_sum   = len[7:0];
						byte_count    = 7'd1;
						phase         = RX_BODY;
					end
				end
				RX_BODY: begin
					if (byte_count < frame_length) begin
						frame_store[byte_count] = b;
						byte_count  = byte_count + 7'd1;
						running_sum = running_sum + b;
					end
					if (byte_count >= frame_length)
						phase = RX_CHECK;
				end
				default: begin
					if (b == running_sum) begin
						plen = frame_length - 2;
						if (plen == 0) begin
							r = '{command: frame_store[1], data_byte: 8'd0, byte_index: 6'd0,
								payload_length: 6'd0, has_data: 1'b0, last: 1'b1};
							expected.push_back(r);
						end else begin
							for (int i = 0; i < plen; i++) begin
								r = '{command: frame_store[1], data_byte: frame_store[2 + i],
									byte_index: i[5:0], payload_length: plen[5:0],
									has_data: 1'b1, last: (i + 1 == plen)};
								expected.push_back(r);
							end
						end
					end
					byte_count = '0;
					phase      = RX_HUNT;
				end
			endcase
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_reply(frame_reply_t got);
			frame_reply_t want;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected: expected none, actual %p",
					$time, got);
				return;
			end
			want = expected.pop_front();
			compare_field("command", want.command, got.command);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("has_data", want.has_data, got.has_data);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic [7:0] rx_byte   = 8'd0;
	logic       pop       = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data  = 8'd0;
	logic       full;
	logic       empty;
	logic       cfg_ready;
	logic [7:0] command;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic [5:0] payload_length;
	logic       has_data;
	logic       last;

	frame_scoreboard sb = new();

	// idling controls, changed by the stimulus with nonblocking writes
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_req  = 1'b0;

	int          sent_bytes  = 0;
	int unsigned cycle_count = 0;

	// hand-built frames checked straight after reset (sync 0x5a)
	bit [7:0] directed_bytes [$] = '{
		// empty payload
		8'h5a, 8'h5a, 8'h02, 8'ha5, 8'ha7,
		// command 0xff, payload 0x00 0xff, sum wraps
		8'h5a, 8'h5a, 8'h04, 8'hff, 8'h00, 8'hff, 8'h02,
		// length zero, then length one: both abandoned
		8'h5a, 8'h5a, 8'h00,
		8'h5a, 8'h5a, 8'h01,
		// lone sync broken by another byte, then a real start, command 0
		8'h5a, 8'h13, 8'h5a, 8'h5a, 8'h02, 8'h00, 8'h02,
		// bad sum: frame dropped
		8'h5a, 8'h5a, 8'h03, 8'h01, 8'h02, 8'h07
	};

	sync_length_checksum_frame_receiver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.rx_byte        (rx_byte),
		.pop            (pop),
		.empty          (empty),
		.command        (command),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.payload_length (payload_length),
		.has_data       (has_data),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: checks the beat taken at this edge, then decides pop for the
	// next one. A requested hold-off is counted here, independent of the sender.
	int stall_left = 0;
	int hold_left  = 0;

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_reply('{command: command, data_byte: data_byte, byte_index: byte_index,
				payload_length: payload_length, has_data: has_data, last: last});
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_left = HOLD_CYCLES - 1;
			hold_req  <= 1'b0;
			pop       <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			pop <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(1, 15)) - 1;
			pop <= 1'b0;
		end else begin
			pop <= arst_n;
		end
	end

	// One rx beat. push is left high on return so back-to-back beats need no
	// gap; anything that waits afterwards must drop it first.
	task automatic send_byte(input bit [7:0] b);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_byte(b);
		sent_bytes++;
	endtask

	function automatic bit [7:0] other_than_sync();
		bit [7:0] v;
		do v = 8'($urandom); while (v == sb.sync_value);
		return v;
	endfunction

	// push non-sync bytes until the receiver is hunting with no sync pending;
	// a half-received frame just runs on to its sum byte
	task automatic resync();
		while (!sb.at_rest()) send_byte(~sb.sync_value);
	endtask

	// sync pair, length, body, sum; body size follows the clamped length
	task automatic send_frame(input bit [7:0] raw_len, input bit corrupt);
		bit [7:0] sum;
		bit [7:0] b;
		int       body;
		body = (raw_len > slcfr_pkg::BUFFER_BYTES) ? slcfr_pkg::BUFFER_BYTES : raw_len;
		sum  = body[7:0];
		send_byte(sb.sync_value);
		send_byte(sb.sync_value);
		send_byte(raw_len);
		repeat (body - 1) begin
			b   = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	// mostly good frames with short bodies; the rest are bad sums, short
	// lengths, broken sync pairs and line noise
	task automatic send_random_frame();
		int       pick;
		int       span;
		bit [7:0] raw_len;
		resync();
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			span = $urandom_range(0, 19);
			if (span < 18)
				raw_len = 8'($urandom_range(2, 10));
			else if (span == 18)
				raw_len = 8'($urandom_range(11, slcfr_pkg::BUFFER_BYTES));
			else
				raw_len = 8'($urandom_range(slcfr_pkg::BUFFER_BYTES + 1, 255));
			send_frame(raw_len, pick >= 62);
		end else if (pick < 82) begin
			send_byte(sb.sync_value);
			send_byte(sb.sync_value);
			send_byte(8'($urandom_range(0, 1)));
		end else if (pick < 90) begin
			send_byte(sb.sync_value);
			send_byte(other_than_sync());
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(other_than_sync());
		end
	endtask

	task automatic run_group();
		int start;
		start = sent_bytes;
		while (sent_bytes - start < GROUP_BYTES) send_random_frame();
	endtask

	// stop pushing and wait for every owed result, then let the front end settle
	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(input bit [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_sync(value);
		cfg_valid <= 1'b0;
	endtask

	// sync is only changed with the receiver hunting and nothing in flight
	task automatic reconfigure(input bit [7:0] value);
		resync();
		drain();
		write_sync(value);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

		// sync of all zeros
		reconfigure(8'h00);
		run_group();

		// receiver holds off while the sender keeps offering whole frames of
		// at least two payload bytes: both banks fill and push stalls on full;
		// then wait for all of it
		resync();
		send_idle <= 1'b0;
		hold_req  <= 1'b1;
		repeat (PRESSURE_FRAMES) send_frame(8'($urandom_range(4, 6)), 1'b0);
		drain();
		send_idle <= 1'b1;

		// sync of all ones
		reconfigure(8'hff);
		run_group();

		reconfigure(8'($urandom));
		run_group();

		// back to the reset value, no idling on either side
		reconfigure(slcfr_pkg::SYNC_RESET);
		send_idle <= 1'b0;
		recv_idle <= 1'b0;
		run_group();

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
